// ===== rtl/circular_entry_journal_top_macros.svh =====
// Assertion macros for the circular entry journal.
// Included by the top level; no other dependencies.
`ifndef CIRCULAR_ENTRY_JOURNAL_TOP_MACROS_SVH
`define CIRCULAR_ENTRY_JOURNAL_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define CEJ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("circular_entry_journal: same-cycle check failed");
// next-cycle implication
`define CEJ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("circular_entry_journal: next-cycle check failed");
`else
`define CEJ_ASSERT_IMP(label, clk, rst, ante, cons)
`define CEJ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/cej_pkg.sv =====
// Shared types and constants for the circular entry journal.
// No dependencies.
package cej_pkg;

   localparam int CAPACITY_DEF  = 2048;
   localparam int MAX_ENTRY_DEF = 256;

   localparam int CmdW   = 2;
   localparam int LenW   = 9;
   localparam int ByteW  = 8;
   localparam int LimitW = 9;

   localparam logic [LimitW-1:0] READ_LIMIT_RESET = 9'd256;

   localparam logic [CmdW-1:0] CMD_BEGIN = 2'd0;
   localparam logic [CmdW-1:0] CMD_BYTE  = 2'd1;
   localparam logic [CmdW-1:0] CMD_READ  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DROP,
      ST_READ,
      ST_POST
   } state_type;

   typedef struct packed {
      logic [ByteW-1:0] out_byte;
      logic             last;
      logic             empty_res;
      logic             status;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ring_ctl_type;

endpackage

// ===== rtl/cej_ifs.sv =====
// Valid/ready channel interfaces for the circular entry journal.
// Depends on cej_pkg for field widths.
interface cej_req_if import cej_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CmdW-1:0]  cmd;
   logic [LenW-1:0]  total_len;
   logic [ByteW-1:0] data_byte;

   modport source (output valid, cmd, total_len, data_byte, input ready);
   modport sink   (input valid, cmd, total_len, data_byte, output ready);
endinterface

interface cej_rsp_if import cej_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] out_byte;
   logic             last;
   logic             empty_res;
   logic             status;

   modport source (output valid, out_byte, last, empty_res, status, input ready);
   modport sink   (input valid, out_byte, last, empty_res, status, output ready);
endinterface

interface cej_csr_if import cej_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [LimitW-1:0] read_limit;

   modport source (output valid, read_limit, input ready);
   modport sink   (input valid, read_limit, output ready);
endinterface

// ===== rtl/circular_entry_journal_top.sv =====
// Circular entry journal: a byte ring of CAPACITY bytes holding zero-terminated
// entries, overwriting the oldest. Depends on cej_pkg, cej_ifs, cej_ring.
//
// One request is worked at a time. An entry byte, an unknown command or a read
// of an empty journal finishes in ST_IDLE; a read of a non-empty journal goes
// on to ST_READ, since the ring's single read port returns data in the cycle
// after the address; a begin that must drop oldest entries goes on to ST_DROP,
// which drops whole oldest entries, reading the ring one byte a cycle. Results
// go to an output register, and a new request is taken while one waits there;
// a second finished result is held until the first is taken.
// The ring is never cleared: free space is counted per stored byte, so only
// written bytes are ever read. Reads and writes never share a cycle, so no
// forwarding is needed. read_limit may only be written while the block is idle.
`include "circular_entry_journal_top_macros.svh"

module circular_entry_journal_top import cej_pkg::*; #(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int MAX_ENTRY = MAX_ENTRY_DEF
) (
   input logic    clock,
   input logic    reset,
   cej_req_if.sink   req_if,
   cej_rsp_if.source rsp_if,
   cej_csr_if.sink   csr_if
);

   localparam int AddrW = $clog2(CAPACITY);
   localparam int FreeW = $clog2(CAPACITY + 1);
   localparam int CmpW  = (FreeW > LenW) ? FreeW : LenW;
   localparam int SumW  = FreeW + 1;
   localparam int LimCapInt = (MAX_ENTRY > 511) ? 511 : MAX_ENTRY;
   localparam logic [LimitW-1:0] LimCap  = LimitW'(LimCapInt);
   localparam logic [FreeW-1:0]  CapF    = FreeW'(CAPACITY);
   localparam logic [AddrW-1:0]  LastIdx = AddrW'(CAPACITY - 1);

   state_type state_ff, state_in;

   logic [AddrW-1:0]  rp_ff, rp_in, wp_ff, wp_in;
   logic [FreeW-1:0]  free_ff, free_in;
   logic [LimitW-1:0] pos_ff, pos_in;
   logic              disc_ff, disc_in;
   logic [LenW-1:0]   resv_ff, resv_in;
   logic [LenW-1:0]   len_ff, len_in;
   logic [LimitW-1:0] lim_ff;

   rsp_type rsp_ff, rsp_in, pend_ff, pend_in, fin_res;
   logic    rspv_ff, rspv_in;

   ring_ctl_type     ring_ctl;
   logic [AddrW-1:0] rd_addr;
   logic [ByteW-1:0] rd_data, wr_data;

   logic             accept, out_free, fin;
   logic             too_long, ring_empty, need_drop, drop_more, read_busy;
   logic [AddrW-1:0] rp_nxt, wp_nxt;
   logic [FreeW-1:0] free_inc;
   logic [LimitW-1:0] lim;
   logic [LimitW:0]  pos_inc;
   logic             lim_hit;

   cej_ring #(.CAPACITY(CAPACITY)) u_ring (
      .clock   (clock),
      .ctl     (ring_ctl),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign csr_if.ready     = 1'b1;
   assign rsp_if.valid     = rspv_ff;
   assign rsp_if.out_byte  = rsp_ff.out_byte;
   assign rsp_if.last      = rsp_ff.last;
   assign rsp_if.empty_res = rsp_ff.empty_res;
   assign rsp_if.status    = rsp_ff.status;

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rspv_ff || rsp_if.ready;

   assign rp_nxt   = (rp_ff == LastIdx) ? '0 : rp_ff + 1'b1;
   assign wp_nxt   = (wp_ff == LastIdx) ? '0 : wp_ff + 1'b1;
   assign free_inc = free_ff + 1'b1;

   assign too_long   = CmpW'(req_if.total_len) > CmpW'(CAPACITY);
   assign ring_empty = (free_ff == CapF);
   assign need_drop  = (CmpW'(free_ff) < CmpW'(req_if.total_len)) && !ring_empty;
   // keep walking while the ring holds bytes and either the entry has not
   // ended or there is still not enough room
   assign drop_more  = (free_inc != CapF) &&
                       ((rd_data != '0) || (CmpW'(free_inc) < CmpW'(len_ff)));
   assign read_busy  = (req_if.cmd == CMD_READ) && !ring_empty;

   // effective limit: min(read_limit, MAX_ENTRY), zero counts as one
   assign lim     = (lim_ff == '0) ? LimitW'(1) : ((lim_ff > LimCap) ? LimCap : lim_ff);
   assign pos_inc = {1'b0, pos_ff} + 1'b1;
   assign lim_hit = pos_inc >= {1'b0, lim};

   assign fin = (state_ff == ST_IDLE && accept &&
                 !((req_if.cmd == CMD_BEGIN) && !too_long && need_drop) && !read_busy) ||
                (state_ff == ST_DROP && !drop_more) ||
                (state_ff == ST_READ);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_if.cmd == CMD_BEGIN) && !too_long && need_drop) begin
                  state_in = ST_DROP;
               end else if (read_busy) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_DROP, ST_READ: begin
         end
         ST_POST: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (fin) begin
         state_in = out_free ? ST_IDLE : ST_POST;
      end
   end

   // datapath and outputs
   always_comb begin
      rp_in    = rp_ff;
      wp_in    = wp_ff;
      free_in  = free_ff;
      pos_in   = pos_ff;
      disc_in  = disc_ff;
      resv_in  = resv_ff;
      len_in   = len_ff;
      ring_ctl = '0;
      rd_addr  = rp_ff;
      wr_data  = req_if.data_byte;
      fin_res  = '0;
      pend_in  = pend_ff;
      rsp_in   = rsp_ff;
      rspv_in  = rspv_ff && !rsp_if.ready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_if.cmd)
                  CMD_BEGIN: begin
                     if (too_long) begin
                        fin_res.status = 1'b1;
                        disc_in        = 1'b1;
                        resv_in        = '0;
                     end else begin
                        disc_in = 1'b0;
                        resv_in = req_if.total_len;
                        len_in  = req_if.total_len;
                        ring_ctl.rd_en = need_drop;
                     end
                  end
                  CMD_BYTE: begin
                     if (!disc_ff && (resv_ff != '0) && (free_ff != '0)) begin
                        ring_ctl.wr_en = 1'b1;
                        // last reserved byte is the terminator
                        if (resv_ff == LenW'(1)) begin
                           wr_data = '0;
                        end
                        wp_in   = wp_nxt;
                        free_in = free_ff - 1'b1;
                        resv_in = resv_ff - 1'b1;
                     end
                  end
                  CMD_READ: begin
                     if (ring_empty) begin
                        fin_res.empty_res = 1'b1;
                     end else begin
                        ring_ctl.rd_en = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DROP: begin
            rp_in   = rp_nxt;
            free_in = free_inc;
            pos_in  = '0;
            rd_addr = rp_nxt;
            ring_ctl.rd_en = drop_more;
         end
         ST_READ: begin
            rp_in   = rp_nxt;
            free_in = free_inc;
            if (lim_hit) begin
               fin_res.last = 1'b1;
               pos_in       = '0;
            end else if (rd_data == '0) begin
               fin_res.last = 1'b1;
               pos_in       = '0;
            end else begin
               fin_res.out_byte = rd_data;
               pos_in           = pos_inc[LimitW-1:0];
            end
         end
         ST_POST: begin
            if (out_free) begin
               rsp_in  = pend_ff;
               rspv_in = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (fin) begin
         if (out_free) begin
            rsp_in  = fin_res;
            rspv_in = 1'b1;
         end else begin
            pend_in = fin_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rp_ff    <= '0;
         wp_ff    <= '0;
         free_ff  <= CapF;
         pos_ff   <= '0;
         disc_ff  <= 1'b0;
         resv_ff  <= '0;
         rspv_ff  <= 1'b0;
         lim_ff   <= READ_LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         rp_ff    <= rp_in;
         wp_ff    <= wp_in;
         free_ff  <= free_in;
         pos_ff   <= pos_in;
         disc_ff  <= disc_in;
         resv_ff  <= resv_in;
         rspv_ff  <= rspv_in;
         if (csr_if.valid && csr_if.ready) begin
            lim_ff <= csr_if.read_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   // write pointer must sit exactly the stored byte count past the read pointer
   logic [SumW-1:0] chk_sum, chk_wp;
   logic            ptr_ok;
   assign chk_sum = SumW'(rp_ff) + SumW'(CapF - free_ff);
   assign chk_wp  = (chk_sum >= SumW'(CAPACITY)) ? chk_sum - SumW'(CAPACITY) : chk_sum;
   assign ptr_ok  = (chk_wp == SumW'(wp_ff)) && (free_ff <= CapF);

   `CEJ_ASSERT_IMP(a_ptr_consistent, clock, reset, 1'b1, ptr_ok)
   `CEJ_ASSERT_IMP(a_drop_nonempty, clock, reset, state_ff == ST_DROP, free_ff != CapF)
   `CEJ_ASSERT_NXT(a_read_fetch, clock, reset, accept && read_busy, state_ff == ST_READ)

endmodule

// ===== rtl/cej_ring.sv =====
// Byte ring storage: one write port, one read port with registered data.
// Depends on cej_pkg (ring_ctl_type, ByteW).
module cej_ring import cej_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int AddrW = $clog2(CAPACITY)
) (
   input  logic             clock,
   input  ring_ctl_type     ctl,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [ByteW-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [ByteW-1:0] rd_data
);

   logic [ByteW-1:0] ring_ff [CAPACITY];
   logic [ByteW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         ring_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= ring_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
